>>> hw/rtl/mcg_pkg.sv
// Shared types, constants and month tables for the month calendar grid block.
package mcg_pkg;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [4:0] day_number;
    logic [2:0] column;
    logic [2:0] row;
    logic       selected;
    logic       last;
  } grid_t;

  typedef struct packed {
    logic load;
    logic step1;
    logic step2;
    logic step3;
    logic step4;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic month_ok;
    logic last_day;
  } dp_status_t;

  localparam logic [11:0] BASE_YEAR     = 12'd2000;
  localparam logic [8:0]  DAYS_IN_YEAR  = 9'd365;
  // leap years in 1..1999
  localparam logic [9:0]  LEAPS_TO_BASE = 10'd484;
  localparam logic [6:0]  CENTURY       = 7'd100;
  // floor(x / 25) = (x * 1311) >> 15 for x below 1024
  localparam logic [10:0] RECIP_25      = 11'd1311;
  localparam int unsigned RECIP_SHIFT   = 15;
  localparam logic [2:0]  WEEK          = 3'd7;
  localparam logic [2:0]  SUNDAY        = 3'd7;
  localparam logic [2:0]  MONDAY        = 3'd1;
  // 1 Jan 2000 is a Saturday: column = ((count + 4) mod 7) + 1
  localparam logic [2:0]  WEEKDAY_BIAS  = 3'd4;
  localparam logic [3:0]  JANUARY       = 4'd1;
  localparam logic [3:0]  FEBRUARY      = 4'd2;
  localparam logic [3:0]  DECEMBER      = 4'd12;

  localparam logic [4:0] DAYS_IN_MONTH [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

>>> hw/rtl/mcg_ctrl.sv
// Sequencer for the month calendar grid: date capture, weekday steps, cell emission.
module mcg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                date_valid,
  output logic                date_ready,
  output logic                grid_valid,
  input  logic                grid_ready,
  input  mcg_pkg::dp_status_t status,
  output mcg_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STEP1 = 6'b000010,
    S_STEP2 = 6'b000100,
    S_STEP3 = 6'b001000,
    S_STEP4 = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    date_ready = (state == S_IDLE);
    grid_valid = (state == S_EMIT);
    unique case (state)
      S_IDLE: begin
        if (date_valid) begin
          cmd.load   = 1'b1;
          state_next = S_STEP1;
        end
      end
      S_STEP1: begin
        // a month outside 1..12 drops the item
        if (status.month_ok) begin
          cmd.step1  = 1'b1;
          state_next = S_STEP2;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_STEP2: begin
        cmd.step2  = 1'b1;
        state_next = S_STEP3;
      end
      S_STEP3: begin
        cmd.step3  = 1'b1;
        state_next = S_STEP4;
      end
      S_STEP4: begin
        cmd.step4  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (grid_ready) begin
          cmd.advance = 1'b1;
          if (status.last_day) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/mcg_dp.sv
// Datapath: leap rule, day count since the base date, weekday and grid position counters.
module mcg_dp (
  input  logic                clk,
  input  logic                rst,
  input  mcg_pkg::date_t      date,
  input  mcg_pkg::dp_cmd_t    cmd,
  output mcg_pkg::dp_status_t status,
  output mcg_pkg::grid_t      grid
);

  function automatic logic [2:0] mod7(input logic [20:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = '0;
    // 8 = 1 mod 7, so octal digits sum to the same residue
    for (int i = 0; i < 7; i++) begin
      s1 = s1 + 6'(v[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'(mcg_pkg::WEEK)) begin
      s2 = s2 - 4'(mcg_pkg::WEEK);
    end
    return s2[2:0];
  endfunction

  // captured item
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;

  // weekday pipeline
  logic [9:0]  q4;
  logic [5:0]  q100;
  logic [11:0] yoff;
  logic        after_base;
  logic        leap;
  logic [10:0] leaps;
  logic [19:0] yterm;
  logic [9:0]  month_off;
  logic [20:0] count;

  // grid state
  logic [4:0]  day_counter;
  logic [4:0]  month_length;
  logic [2:0]  current_column;
  logic [2:0]  current_row;

  logic [3:0]  mi;
  logic [20:0] q4_prod;
  logic        after_base_c;
  logic [12:0] cent;
  logic        century_c;
  logic        leap_c;
  logic [20:0] year_part;
  logic [20:0] biased;

  assign mi           = month_q - mcg_pkg::JANUARY;
  assign q4_prod      = 21'(year_q[11:2]) * 21'(mcg_pkg::RECIP_25);
  assign after_base_c = (year_q > mcg_pkg::BASE_YEAR);
  assign cent         = 13'(q100) * 13'(mcg_pkg::CENTURY);
  assign century_c    = (cent == {1'b0, year_q});
  assign leap_c       = ((year_q[1:0] == 2'b00) && !century_c) ||
                        (century_c && (q100[1:0] == 2'b00));
  assign year_part    = after_base ?
                        (21'(yterm) + 21'(leaps) - 21'(leap) - 21'(mcg_pkg::LEAPS_TO_BASE)) :
                        '0;
  assign biased       = count + 21'(mcg_pkg::WEEKDAY_BIAS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_q  <= date.year;
      month_q <= date.month;
      day_q   <= date.day;
    end
    if (cmd.step1) begin
      q4         <= year_q[11:2];
      q100       <= q4_prod[mcg_pkg::RECIP_SHIFT +: 6];
      after_base <= after_base_c;
      yoff       <= after_base_c ? (year_q - mcg_pkg::BASE_YEAR) : '0;
    end
    if (cmd.step2) begin
      leap      <= leap_c;
      // leaps in 1..year; the current year's own leap is taken off in step 3
      leaps     <= 11'(q4) - 11'(q100) + 11'(q100[5:2]);
      yterm     <= 20'(yoff) * 20'(mcg_pkg::DAYS_IN_YEAR);
      month_off <= 10'(mcg_pkg::DAYS_BEFORE_MONTH[mi]) +
                   10'(leap_c && (month_q > mcg_pkg::FEBRUARY)) + 10'd1;
    end
    if (cmd.step3) begin
      count <= year_part + 21'(month_off);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day_counter    <= '0;
      month_length   <= '0;
      current_column <= mcg_pkg::MONDAY;
      current_row    <= '0;
    end else begin
      if (cmd.step2) begin
        month_length <= mcg_pkg::DAYS_IN_MONTH[mi] +
                        5'(leap_c && (month_q == mcg_pkg::FEBRUARY));
      end
      if (cmd.step4) begin
        day_counter    <= 5'd1;
        current_column <= mod7(biased) + 3'd1;
        current_row    <= '0;
      end else if (cmd.advance) begin
        // day count holds at the last day of the month
        if (day_counter != month_length) begin
          day_counter <= day_counter + 5'd1;
        end
        if (current_column == mcg_pkg::SUNDAY) begin
          current_column <= mcg_pkg::MONDAY;
          current_row    <= current_row + 3'd1;
        end else begin
          current_column <= current_column + 3'd1;
        end
      end
    end
  end

  assign status.month_ok = (month_q >= mcg_pkg::JANUARY) && (month_q <= mcg_pkg::DECEMBER);
  assign status.last_day = (day_counter == month_length);

  assign grid.day_number = day_counter;
  assign grid.column     = current_column;
  assign grid.row        = current_row;
  assign grid.selected   = (day_counter == day_q);
  assign grid.last       = (day_counter == month_length);

endmodule

>>> hw/rtl/month_calendar_grid_top.sv
// Once a date item is accepted, the four weekday steps run before the first grid item appears.
// Throughput: one grid item per cycle while grid_ready holds. A new date item is
// taken only after the 4-step weekday pipeline and the one-cell-per-cycle emit
// counter are through with the last one. A date with an invalid month yields no grid items.
// Reset (rst, synchronous): sequencer idle, grid counters at day 0, Monday, row 0.
// Top level of the month calendar grid block.
module month_calendar_grid_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           date_valid,
  output logic           date_ready,
  input  mcg_pkg::date_t date,
  output logic           grid_valid,
  input  logic           grid_ready,
  output mcg_pkg::grid_t grid
);

  mcg_pkg::dp_cmd_t    cmd;
  mcg_pkg::dp_status_t status;

  mcg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .date_valid (date_valid),
    .date_ready (date_ready),
    .grid_valid (grid_valid),
    .grid_ready (grid_ready),
    .status     (status),
    .cmd        (cmd)
  );

  mcg_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .date   (date),
    .cmd    (cmd),
    .status (status),
    .grid   (grid)
  );

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(date_ready && grid_valid))
    else $error("date accepted while a month is still being emitted");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    grid_valid |-> (grid.column >= 3'd1) && (grid.column <= 3'd7) && (grid.row <= 3'd5))
    else $error("grid cell outside the week grid");

  a_day_step: assert property (@(posedge clk) disable iff (rst)
    (grid_valid && grid_ready && !grid.last) |=>
      (grid_valid && (grid.day_number == $past(grid.day_number) + 5'd1)))
    else $error("day numbers not consecutive");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (grid_valid && grid_ready && !grid.last && (grid.column == 3'd7)) |=>
      ((grid.column == 3'd1) && (grid.row == $past(grid.row) + 3'd1)))
    else $error("week wrap did not start a new row on Monday");

  a_month_end: assert property (@(posedge clk) disable iff (rst)
    (grid_valid && grid_ready && grid.last) |=> (date_ready && !grid_valid))
    else $error("block not idle after the last day of the month");
`endif

endmodule

>>> sim/tb.sv
// Testbench for month_calendar_grid_top: predicts each month's grid cells and checks them.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_SHOWN   = 10;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           date_valid = 1'b0;
  logic           date_ready;
  mcg_pkg::date_t date = '0;
  logic           grid_valid;
  logic           grid_ready = 1'b0;
  mcg_pkg::grid_t grid;

  mcg_pkg::date_t pending_dates[$];
  mcg_pkg::grid_t expected_cells[$];

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned dates_taken = 0;
  int unsigned dates_ignored = 0;
  int unsigned cells_checked = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // predictor's copy of the layout state
  logic [4:0] cal_day = 5'd0;
  logic [4:0] cal_len = 5'd0;
  logic [2:0] cal_col = 3'd1;
  logic [2:0] cal_row = 3'd0;

  month_calendar_grid_top uut (
    .clk        (clk),
    .rst        (rst),
    .date_valid (date_valid),
    .date_ready (date_ready),
    .date       (date),
    .grid_valid (grid_valid),
    .grid_ready (grid_ready),
    .grid       (grid)
  );

  always #5 clk = ~clk;

  function automatic int unsigned month_days(input int unsigned m);
    case (m)
      2: return 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned days_ahead(input int unsigned m);
    case (m)
      1: return 0;
      2: return 31;
      3: return 59;
      4: return 90;
      5: return 120;
      6: return 151;
      7: return 181;
      8: return 212;
      9: return 243;
      10: return 273;
      11: return 304;
      default: return 334;
    endcase
  endfunction

  function automatic int unsigned leap_count(input int unsigned x);
    return x / 4 - x / 100 + x / 400;
  endfunction

  // Lay out the month of one accepted date and queue its cells.
  task automatic layout_month(input mcg_pkg::date_t d);
    int unsigned    yr;
    int unsigned    mo;
    int unsigned    cnt;
    bit             leap;
    mcg_pkg::grid_t exp_item;
    yr = 32'(d.year);
    mo = 32'(d.month);
    if (mo < 1 || mo > 12) begin
      dates_ignored++;
      return;
    end
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    cnt = 0;
    // years before the base count no whole years
    if (yr > 2000)
      cnt = 365 * (yr - 2000) + (leap_count(yr - 1) - leap_count(1999));
    cnt += days_ahead(mo);
    if (leap && mo > 2)
      cnt += 1;
    cnt += 1;
    cal_len = 5'(month_days(mo) + ((leap && mo == 2) ? 1 : 0));
    cal_col = 3'(((cnt + 4) % 7) + 1);
    cal_row = 3'd0;
    for (int unsigned dn = 1; dn <= 32'(cal_len); dn++) begin
      exp_item.day_number = 5'(dn);
      exp_item.column     = cal_col;
      exp_item.row        = cal_row;
      exp_item.selected   = (dn == 32'(d.day));
      exp_item.last       = (dn == 32'(cal_len));
      expected_cells.push_back(exp_item);
      cal_day = 5'(dn);
      if (cal_col == 3'd7) begin
        cal_col = 3'd1;
        cal_row = cal_row + 3'd1;
      end else begin
        cal_col = cal_col + 3'd1;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      date_valid <= 1'b0;
    end else begin
      if (date_valid && date_ready) begin
        layout_month(date);
        dates_taken++;
      end
      if (!date_valid || date_ready) begin
        if (pending_dates.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          date       <= pending_dates.pop_front();
          date_valid <= 1'b1;
        end else begin
          date_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mcg_pkg::grid_t want;
    if (rst) begin
      grid_ready <= 1'b0;
    end else begin
      grid_ready <= ($urandom_range(99) >= sink_idle_pct);
      if (grid_valid && grid_ready) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected cell: day %0d col %0d row %0d sel %0b last %0b",
                     grid.day_number, grid.column, grid.row, grid.selected, grid.last);
        end else begin
          want = expected_cells.pop_front();
          cells_checked++;
          if (grid.day_number !== want.day_number || grid.column !== want.column ||
              grid.row !== want.row || grid.selected !== want.selected ||
              grid.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("cell mismatch (day/col/row/sel/last): exp %0d/%0d/%0d/%0b/%0b, %s",
                       want.day_number, want.column, want.row, want.selected, want.last,
                       $sformatf("got %0d/%0d/%0d/%0b/%0b", grid.day_number, grid.column,
                                 grid.row, grid.selected, grid.last));
          end
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((date_valid && date_ready) || (grid_valid && grid_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_date(input int unsigned y, input int unsigned m, input int unsigned d);
    mcg_pkg::date_t it;
    it.year  = 12'(y);
    it.month = 4'(m);
    it.day   = 5'(d);
    pending_dates.push_back(it);
  endtask

  task automatic add_random_dates(input int unsigned count);
    int unsigned r;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 78)
        y = $urandom_range(4095, 2000);
      else if (r < 92)
        y = 100 * $urandom_range(40, 20) + $urandom_range(1);  // century edges
      else
        y = $urandom_range(1999);
      if ($urandom_range(99) < 92) begin
        m = $urandom_range(12, 1);
      end else begin
        m = $urandom_range(3);
        if (m != 0)
          m = m + 12;
      end
      if ($urandom_range(99) < 88)
        d = $urandom_range(31, 1);
      else
        d = $urandom_range(31);
      add_date(y, m, d);
    end
  endtask

  task automatic drain;
    while (pending_dates.size() != 0 || date_valid || expected_cells.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: range ends, leap rule corners, ignored months, unflagged days
    add_date(2000, 1, 1);
    add_date(4095, 12, 31);
    add_date(0, 1, 0);
    add_date(2000, 2, 29);
    add_date(2100, 2, 29);
    add_date(2004, 2, 31);
    add_date(2400, 2, 29);
    add_date(4000, 2, 28);
    add_date(1999, 2, 28);
    add_date(1900, 2, 29);
    add_date(1600, 3, 1);
    add_date(2000, 0, 5);
    add_date(2023, 13, 5);
    add_date(4095, 15, 31);
    add_date(2001, 1, 31);
    add_date(2015, 2, 1);
    add_date(2016, 4, 31);
    add_date(2017, 7, 16);
    add_date(2026, 8, 15);
    add_date(3000, 6, 30);
    add_date(2047, 9, 0);
    add_date(2099, 10, 10);
    add_date(2999, 11, 21);
    add_date(2024, 5, 31);
    drain();

    add_random_dates(90);
    drain();

    src_idle_pct = 59;
    add_random_dates(85);
    drain();

    src_idle_pct = 0;
    sink_idle_pct = 59;
    add_random_dates(85);
    drain();

    src_idle_pct = 20;
    sink_idle_pct = 20;
    add_random_dates(90);
    drain();

    $display("%0d dates taken (%0d with no valid month), %0d grid cells checked",
             dates_taken, dates_ignored, cells_checked);
    $display("idle mixes: none, sender 59%%, receiver 59%%, both 20%%; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
